>>> rtl/ncq_pkg.sv
// Shared types and constants for the nearest color quantizer.
`default_nettype none
package ncq_pkg;

   localparam int MAX_COLORS = 16;
   localparam int IDX_W      = $clog2(MAX_COLORS);
   localparam int SEARCH_CAP = (MAX_COLORS < 16) ? MAX_COLORS : 16;
   localparam int CNT_W      = 5;
   localparam int DIST_W     = 18;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [3:0] entry_index;
      logic [7:0] entry_c0;
      logic [7:0] entry_c1;
      logic [7:0] entry_c2;
      logic [7:0] pixel_c0;
      logic [7:0] pixel_c1;
      logic [7:0] pixel_c2;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] out_c0;
      logic [7:0] out_c1;
      logic [7:0] out_c2;
      logic [3:0] chosen_index;
   } rsp_beat_type;

   typedef struct packed {
      logic             load;
      logic             capture;
      logic             issue;
      logic             issue_first;
      logic             issue_last;
      logic [IDX_W-1:0] rd_idx;
      logic             publish;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

>>> rtl/nearest_color_quantizer_top.sv
// Top level of the nearest color quantizer.
// Usage:
//   req channel (req_valid / req_stall / req_data): one beat is either a
//   palette load (req_type = load) that writes entry_index with entry_c0..2,
//   or a pixel (req_type = pixel) that is matched against palette entries
//   0 .. active_colors-1 by squared distance over all three channels.
//   rsp channel (rsp_valid / rsp_stall / rsp_data): one beat per pixel with
//   the winning color and its index; ties go to the lowest index. Loads give
//   no response beat.
//   csr port: csr_wr_en writes active_colors (0 acts as 1, above 16 acts as
//   16). Write only while the block is idle.
// Timing: a load is written at its accepting edge. A pixel's search reads
//   one entry per cycle; its result beat is valid once the last entry has
//   left the pipe and been published; no new beat is taken before that.
// Reset: synchronous, active high; clears control and sets active_colors to
//   1. Palette contents are undefined until loaded.
// Stall: a finished result sits in the output register; the next beat is
//   accepted meanwhile. A further search waits at its end until the output
//   register is free.
`default_nettype none
module nearest_color_quantizer_top (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire ncq_pkg::req_beat_type   req_data,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      ncq_pkg::rsp_beat_type   rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire logic [4:0]              csr_wr_data
);
   import ncq_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: accept, scan count, publish handshake
   ncq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_data.req_type),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .cmd         (cmd)
   );

   // palette memory, 3-stage distance/compare pipe, output register
   ncq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/ncq_ctrl.sv
// Controller: accepts beats, sequences the palette scan, publishes results.
`default_nettype none
module ncq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic                    req_type,
   input  wire logic                    csr_wr_en,
   input  wire logic [4:0]              csr_wr_data,
   input  wire ncq_pkg::dp_stat_type    stat,
   output      ncq_pkg::dp_cmd_type     cmd
);
   import ncq_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [CNT_W-1:0] active_ff;
   logic [IDX_W-1:0] clamp_last;
   logic             accept;

   // zero searches entry 0 only; large counts saturate at the table size
   always_comb begin
      if (active_ff == '0) begin
         clamp_last = '0;
      end else if (active_ff > CNT_W'(SEARCH_CAP)) begin
         clamp_last = IDX_W'(SEARCH_CAP - 1);
      end else begin
         clamp_last = IDX_W'(active_ff - CNT_W'(1));
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      last_in         = last_ff;
      cmd             = '0;
      cmd.rd_idx      = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_PIXEL) begin
                  cmd.capture = 1'b1;
                  idx_in      = '0;
                  last_in     = clamp_last;
                  state_in    = ST_SCAN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue       = 1'b1;
            cmd.issue_first = (idx_ff == '0);
            cmd.issue_last  = (idx_ff == last_ff);
            if (idx_ff == last_ff) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
            if (stat.done && stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         last_ff   <= '0;
         active_ff <= CNT_W'(1);
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         last_ff  <= last_in;
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
      end
   end

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= last_ff))
      else $error("scan index past last entry");

   a_publish_when_done: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (state_ff == ST_FINISH) && stat.done)
      else $error("publish without finished search");

   a_no_issue_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !cmd.issue && !cmd.publish)
      else $error("datapath command while idle");

endmodule
`default_nettype wire

>>> rtl/ncq_datapath.sv
// Datapath: palette memory, distance pipeline, best tracker, output register.
`default_nettype none
module ncq_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ncq_pkg::req_beat_type   req_data,
   input  wire ncq_pkg::dp_cmd_type     cmd,
   output      ncq_pkg::dp_stat_type    stat,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      ncq_pkg::rsp_beat_type   rsp_data
);
   import ncq_pkg::*;

   logic [23:0]       palette_mem [MAX_COLORS];

   logic [7:0]        pix0_ff, pix1_ff, pix2_ff;

   // stage 1: read data
   logic              s1_valid_ff, s1_first_ff, s1_last_ff;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic [23:0]       s1_color_ff;

   // stage 2: channel squares
   logic              s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic [23:0]       s2_color_ff;
   logic [15:0]       sq0_ff, sq1_ff, sq2_ff;

   // best so far
   logic [DIST_W-1:0] best_dist_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [23:0]       best_color_ff;
   logic              done_ff;

   logic              rsp_valid_ff;
   rsp_beat_type      rsp_data_ff;

   logic [7:0]        d0, d1, d2;
   logic [DIST_W-1:0] dist_sum;
   logic              take;

   // load beats always land inside the 16-entry table, whatever active_colors is
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         palette_mem[req_data.entry_index[IDX_W-1:0]] <=
            {req_data.entry_c0, req_data.entry_c1, req_data.entry_c2};
      end
      if (cmd.issue) begin
         s1_color_ff <= palette_mem[cmd.rd_idx];
      end
   end

   always_comb begin
      d0 = (pix0_ff > s1_color_ff[23:16]) ? pix0_ff - s1_color_ff[23:16]
                                           : s1_color_ff[23:16] - pix0_ff;
      d1 = (pix1_ff > s1_color_ff[15:8])  ? pix1_ff - s1_color_ff[15:8]
                                           : s1_color_ff[15:8] - pix1_ff;
      d2 = (pix2_ff > s1_color_ff[7:0])   ? pix2_ff - s1_color_ff[7:0]
                                           : s1_color_ff[7:0] - pix2_ff;
   end

   assign dist_sum = DIST_W'(sq0_ff) + DIST_W'(sq1_ff) + DIST_W'(sq2_ff);
   // strict less-than keeps the lowest index on ties
   assign take = s2_valid_ff && (s2_first_ff || (dist_sum < best_dist_ff));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix0_ff <= req_data.pixel_c0;
         pix1_ff <= req_data.pixel_c1;
         pix2_ff <= req_data.pixel_c2;
      end
      s1_first_ff <= cmd.issue_first;
      s1_last_ff  <= cmd.issue_last;
      s1_idx_ff   <= cmd.rd_idx;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_idx_ff   <= s1_idx_ff;
      s2_color_ff <= s1_color_ff;
      sq0_ff      <= d0 * d0;
      sq1_ff      <= d1 * d1;
      sq2_ff      <= d2 * d2;
      if (take) begin
         best_dist_ff  <= dist_sum;
         best_idx_ff   <= s2_idx_ff;
         best_color_ff <= s2_color_ff;
      end
      if (cmd.publish) begin
         rsp_data_ff.out_c0       <= best_color_ff[23:16];
         rsp_data_ff.out_c1       <= best_color_ff[15:8];
         rsp_data_ff.out_c2       <= best_color_ff[7:0];
         rsp_data_ff.chosen_index <= 4'(best_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.publish) begin
            done_ff <= 1'b0;
         end else if (s2_valid_ff && s2_last_ff) begin
            done_ff <= 1'b1;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.done     = done_ff;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !s1_valid_ff && !s2_valid_ff)
      else $error("search done while entries still in flight");

   a_rsp_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.publish))
      else $error("result beat without publish");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> stat.out_free)
      else $error("publish over a stalled result beat");

endmodule
`default_nettype wire
